// ===== sv/dvbs2_bit_deinterleaver_macros.svh =====
// Assertion macros for the bit deinterleaver; clk and rst_n are taken from the caller's scope.
`ifndef DVBS2_BIT_DEINTERLEAVER_MACROS_SVH
`define DVBS2_BIT_DEINTERLEAVER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DBI_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbi: assertion failed");

`define DBI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbi: assertion failed");

`else

`define DBI_ASSERT_IMM(label, ante, cons)

`define DBI_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== sv/dbi_pkg.sv =====
package dbi_pkg;

    localparam int FRAME_MAX_DEF = 64800;
    localparam int LEN_NORMAL    = 64800;
    localparam int LEN_SHORT     = 16200;

    localparam int CNT_W      = 17;
    localparam int ROW_W      = 15;
    localparam int COL_W      = 3;
    localparam int ADDR_W     = CNT_W + 2;
    localparam int VAL_W      = 8;
    localparam int MOD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE35     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd3;

    // modulation codes
    localparam logic [MOD_W-1:0] MODE_QPSK   = 2'd0;
    localparam logic [MOD_W-1:0] MODE_8PSK   = 2'd1;
    localparam logic [MOD_W-1:0] MODE_16APSK = 2'd2;
    localparam logic [MOD_W-1:0] MODE_32APSK = 2'd3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic STATUS_VALID     = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    localparam logic DIR_DEINTERLEAVE = 1'b0;

    typedef struct packed {
        logic accept;
        logic mem_en;
        logic load_out;
    } dbi_cmd_t;

    typedef struct packed {
        logic has_result;
    } dbi_stat_t;

endpackage

// ===== sv/dbi_in_if.sv =====
interface dbi_in_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [dbi_pkg::VAL_W-1:0] sample_value;

    modport source (output valid, output cmd, output sample_value, input ready);
    modport sink   (input valid, input cmd, input sample_value, output ready);
endinterface

// ===== sv/dbi_out_if.sv =====
interface dbi_out_if;
    logic                      valid;
    logic                      ready;
    logic [dbi_pkg::VAL_W-1:0] out_value;
    logic                      last_of_frame;
    logic                      status;

    modport source (output valid, output out_value, output last_of_frame, output status,
                    input ready);
    modport sink   (input valid, input out_value, input last_of_frame, input status,
                    output ready);
endinterface

// ===== sv/dvbs2_bit_deinterleaver.sv =====
// DVB-S2 frame bit deinterleaver / interleaver for 8-bit soft or hard bits.
// Input channel din carries cmd and sample_value: cmd write stores one value
// into the frame RAM, cmd read asks for the next value of the frame.
// Output channel dout returns one word per read: out_value, last_of_frame and
// status (status set means the frame is not yet full and out_value is zero).
// Writes produce no word; writes to a full frame are dropped.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// A write reaches the RAM in the cycle after it is accepted; a read word goes
// through the RAM read register and the output register to dout. No new word
// is accepted until the sequencer has given the last one its access to the
// single-port frame RAM and, for a read, its output-register load.
// Reset clears the configuration and all frame counters; the RAM contents
// are not cleared and hold no meaning until written.
// When the receiver stalls, the word waits in the output register; the next
// word may be accepted, but its result is held until the register frees and
// din stays blocked meanwhile.
module dvbs2_bit_deinterleaver #(
    parameter int FRAME_MAX = dbi_pkg::FRAME_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dbi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbi_pkg::CFG_DATA_W-1:0] cfg_data,
    dbi_in_if.sink                         din,
    dbi_out_if.source                      dout
);

`include "dvbs2_bit_deinterleaver_macros.svh"

    dbi_pkg::dbi_cmd_t  dp_cmd;
    dbi_pkg::dbi_stat_t dp_stat;

    dbi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .din_valid  (din.valid),
        .din_ready  (din.ready),
        .dout_valid (dout.valid),
        .dout_ready (dout.ready),
        .stat       (dp_stat),
        .cmd        (dp_cmd)
    );

    dbi_datapath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (din.cmd),
        .in_sample  (din.sample_value),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .out_value  (dout.out_value),
        .out_last   (dout.last_of_frame),
        .out_status (dout.status)
    );

    `DBI_ASSERT_NXT(a_one_word_in_flight, din.valid && din.ready, !din.ready)
    `DBI_ASSERT_IMM(a_no_overwrite, dp_cmd.load_out, !dout.valid || dout.ready)
    `DBI_ASSERT_IMM(a_not_ready_not_last, dout.valid && dout.status, !dout.last_of_frame)

endmodule

// ===== sv/dbi_ctrl.sv =====
module dbi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               din_valid,
    output logic               din_ready,
    output logic               dout_valid,
    input  logic               dout_ready,
    input  dbi_pkg::dbi_stat_t stat,
    output dbi_pkg::dbi_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MEM,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        din_ready    = (state_reg == S_IDLE);
        cmd.accept   = din_ready && din_valid;
        cmd.mem_en   = (state_reg == S_MEM);
        cmd.load_out = (state_reg == S_OUT) && (!out_valid_reg || dout_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !dout_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (din_valid)
                begin
                    state_next = S_MEM;
                end
            end
            S_MEM:
            begin
                state_next = stat.has_result ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (cmd.load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign dout_valid = out_valid_reg;

endmodule

// ===== sv/dbi_datapath.sv =====
module dbi_datapath #(
    parameter int FRAME_MAX = dbi_pkg::FRAME_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dbi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbi_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_cmd,
    input  logic [dbi_pkg::VAL_W-1:0]      in_sample,
    input  dbi_pkg::dbi_cmd_t              cmd,
    output dbi_pkg::dbi_stat_t             stat,
    output logic [dbi_pkg::VAL_W-1:0]      out_value,
    output logic                           out_last,
    output logic                           out_status
);

    localparam int CW     = dbi_pkg::CNT_W;
    localparam int RW     = dbi_pkg::ROW_W;
    localparam int COLW   = dbi_pkg::COL_W;
    localparam int AW     = dbi_pkg::ADDR_W;
    localparam int PW     = COLW + RW;
    localparam int VW     = dbi_pkg::VAL_W;
    localparam int MW     = dbi_pkg::MOD_W;
    localparam int MEM_AW = $clog2(FRAME_MAX);

    localparam int LEN_N = (FRAME_MAX < dbi_pkg::LEN_NORMAL) ? FRAME_MAX : dbi_pkg::LEN_NORMAL;
    localparam int LEN_S = (FRAME_MAX < dbi_pkg::LEN_SHORT) ? FRAME_MAX : dbi_pkg::LEN_SHORT;

    localparam int LEN_N2 = LEN_N - LEN_N % 2;
    localparam int LEN_N3 = LEN_N - LEN_N % 3;
    localparam int LEN_N4 = LEN_N - LEN_N % 4;
    localparam int LEN_N5 = LEN_N - LEN_N % 5;
    localparam int LEN_S2 = LEN_S - LEN_S % 2;
    localparam int LEN_S3 = LEN_S - LEN_S % 3;
    localparam int LEN_S4 = LEN_S - LEN_S % 4;
    localparam int LEN_S5 = LEN_S - LEN_S % 5;

    localparam int ROWS_N3 = LEN_N3 / 3;
    localparam int ROWS_N4 = LEN_N4 / 4;
    localparam int ROWS_N5 = LEN_N5 / 5;
    localparam int ROWS_S3 = LEN_S3 / 3;
    localparam int ROWS_S4 = LEN_S4 / 4;
    localparam int ROWS_S5 = LEN_S5 / 5;

    // configuration
    logic [MW-1:0] mod_reg;
    logic          short_reg;
    logic          rate35_reg;
    logic          dir_reg;

    // frame state
    logic [CW-1:0]   wc_reg, wc_next;
    logic [CW-1:0]   rc_reg, rc_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [COLW-1:0] col_reg, col_next;
    logic            full_reg, full_next;

    // per-word state
    logic              op_write_reg, op_write_next;
    logic              op_read_reg, op_read_next;
    logic              has_result_reg, has_result_next;
    logic [MEM_AW-1:0] addr_reg;
    logic [VW-1:0]     sample_reg;
    logic              res_zero_reg, res_zero_next;
    logic              res_status_reg, res_status_next;
    logic              res_last_reg, res_last_next;
    logic [VW-1:0]     rdata_reg;
    logic [VW-1:0]     out_value_reg;
    logic              out_last_reg;
    logic              out_status_reg;

    logic [VW-1:0] mem [FRAME_MAX];

    logic [CW-1:0]   len_sel;
    logic [RW-1:0]   rows_sel;
    logic [COLW-1:0] m_val;
    logic            full_eff;
    logic            is_write;
    logic            use_perm;
    logic [CW-1:0]   cnt_sel;
    logic [COLW-1:0] col_eff;
    logic            col_bad;
    logic [PW-1:0]   prod;
    logic [AW-1:0]   addr_full;
    logic            addr_ok;
    logic [COLW-1:0] col_inc, col_adv;
    logic [RW-1:0]   row_adv;
    logic [CW-1:0]   wc_inc;
    logic [CW:0]     rc_inc;
    logic            last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg    <= '0;
            short_reg  <= 1'b0;
            rate35_reg <= 1'b0;
            dir_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dbi_pkg::CFG_MODULATION: mod_reg    <= cfg_data[MW-1:0];
                dbi_pkg::CFG_SHORT:      short_reg  <= cfg_data[0];
                dbi_pkg::CFG_RATE35:     rate35_reg <= cfg_data[0];
                dbi_pkg::CFG_DIRECTION:  dir_reg    <= cfg_data[0];
                default:                 mod_reg    <= mod_reg;
            endcase
        end
    end

    always_comb
    begin
        m_val = COLW'(mod_reg) + COLW'(2);
        case (mod_reg)
            dbi_pkg::MODE_QPSK:
            begin
                len_sel  = short_reg ? CW'(LEN_S2) : CW'(LEN_N2);
                rows_sel = '0;
            end
            dbi_pkg::MODE_8PSK:
            begin
                len_sel  = short_reg ? CW'(LEN_S3) : CW'(LEN_N3);
                rows_sel = short_reg ? RW'(ROWS_S3) : RW'(ROWS_N3);
            end
            dbi_pkg::MODE_16APSK:
            begin
                len_sel  = short_reg ? CW'(LEN_S4) : CW'(LEN_N4);
                rows_sel = short_reg ? RW'(ROWS_S4) : RW'(ROWS_N4);
            end
            dbi_pkg::MODE_32APSK:
            begin
                len_sel  = short_reg ? CW'(LEN_S5) : CW'(LEN_N5);
                rows_sel = short_reg ? RW'(ROWS_S5) : RW'(ROWS_N5);
            end
            default:
            begin
                len_sel  = '0;
                rows_sel = '0;
            end
        endcase
    end

    // address of the current word: linear, pair-swapped (QPSK) or column-major
    always_comb
    begin
        full_eff = full_reg || (wc_reg >= len_sel);
        is_write = (in_cmd == dbi_pkg::CMD_WRITE);
        use_perm = (is_write == (dir_reg == dbi_pkg::DIR_DEINTERLEAVE));
        cnt_sel  = is_write ? wc_reg : rc_reg;

        col_eff = col_reg;
        col_bad = 1'b0;
        if (mod_reg == dbi_pkg::MODE_8PSK && rate35_reg)
        begin
            if (col_reg <= COLW'(2))
            begin
                col_eff = COLW'(2) - col_reg;
            end
            else
            begin
                col_bad = 1'b1;
            end
        end
        prod = PW'(col_eff) * PW'(rows_sel);

        if (!use_perm)
        begin
            addr_full = AW'(cnt_sel);
        end
        else if (mod_reg == dbi_pkg::MODE_QPSK)
        begin
            addr_full = AW'(cnt_sel ^ CW'(1));
        end
        else
        begin
            addr_full = AW'(prod) + AW'(row_reg);
        end
        addr_ok = !(use_perm && mod_reg != dbi_pkg::MODE_QPSK && col_bad)
                  && (addr_full < AW'(FRAME_MAX));
    end

    always_comb
    begin
        col_inc = col_reg + COLW'(1);
        if (col_inc >= m_val)
        begin
            col_adv = '0;
            row_adv = row_reg + RW'(1);
        end
        else
        begin
            col_adv = col_inc;
            row_adv = row_reg;
        end
        wc_inc = wc_reg + CW'(1);
        rc_inc = {1'b0, rc_reg} + (CW+1)'(1);
        last   = (rc_inc >= {1'b0, len_sel});
    end

    always_comb
    begin
        wc_next         = wc_reg;
        rc_next         = rc_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        full_next       = full_reg;
        op_write_next   = op_write_reg;
        op_read_next    = op_read_reg;
        has_result_next = has_result_reg;
        res_zero_next   = res_zero_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        if (cmd.accept)
        begin
            full_next       = full_eff;
            op_write_next   = is_write && !full_eff && addr_ok;
            op_read_next    = !is_write && full_eff && addr_ok;
            has_result_next = !is_write;
            res_zero_next   = !full_eff || !addr_ok;
            res_status_next = full_eff ? dbi_pkg::STATUS_VALID : dbi_pkg::STATUS_NOT_READY;
            res_last_next   = full_eff && last;
            if (is_write && !full_eff)
            begin
                wc_next  = wc_inc;
                row_next = row_adv;
                col_next = col_adv;
                if (wc_inc >= len_sel)
                begin
                    full_next = 1'b1;
                    row_next  = '0;
                    col_next  = '0;
                end
            end
            else if (!is_write && full_eff)
            begin
                if (last)
                begin
                    // start a new frame
                    wc_next   = '0;
                    rc_next   = '0;
                    row_next  = '0;
                    col_next  = '0;
                    full_next = 1'b0;
                end
                else
                begin
                    rc_next  = rc_inc[CW-1:0];
                    row_next = row_adv;
                    col_next = col_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg         <= '0;
            rc_reg         <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            full_reg       <= 1'b0;
            op_write_reg   <= 1'b0;
            op_read_reg    <= 1'b0;
            has_result_reg <= 1'b0;
        end
        else
        begin
            wc_reg         <= wc_next;
            rc_reg         <= rc_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            full_reg       <= full_next;
            op_write_reg   <= op_write_next;
            op_read_reg    <= op_read_next;
            has_result_reg <= has_result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_zero_reg   <= res_zero_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        if (cmd.accept)
        begin
            addr_reg   <= addr_full[MEM_AW-1:0];
            sample_reg <= in_sample;
        end
    end

    // frame RAM: at most one access per word
    always_ff @(posedge clk)
    begin
        if (cmd.mem_en && op_write_reg)
        begin
            mem[addr_reg] <= sample_reg;
        end
        if (cmd.mem_en && op_read_reg)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg  <= res_zero_reg ? '0 : rdata_reg;
            out_last_reg   <= res_last_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.has_result = has_result_reg;
    assign out_value       = out_value_reg;
    assign out_last        = out_last_reg;
    assign out_status      = out_status_reg;

endmodule
